// File: src/gsa_pkg.sv
// Shared types and constants for the generational slot allocator.
// No dependencies; imported by every module of the block but gsa_ram.
`default_nettype none

package gsa_pkg;

  typedef enum logic [1:0] {
    OP_ACQUIRE  = 2'd0,
    OP_RELEASE  = 2'd1,
    OP_END_PASS = 2'd2,
    OP_QUERY    = 2'd3
  } op_e;

  localparam int CFG_AW = 1;
  localparam int CFG_DW = 7;

  localparam logic [CFG_AW-1:0] CFG_SLOT_COUNT    = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_READBACK_MODE = 1'b1;

  localparam int IDX_W    = 6;
  localparam int GEN_W    = 32;
  localparam int OFS_W    = 9;
  localparam int IN_DW    = 40;
  localparam int IN_UW    = 2;
  localparam int OUT_DW   = 56;

  typedef struct packed {
    logic refill;
    logic push;
    logic pop;
  } stk_cmd_t;

endpackage

`default_nettype wire

// File: src/gsa_ram.sv
// Generic simple RAM: one write port, two registered read ports.
// Read during write on the same address returns the old data.
`default_nettype none

module gsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem[raddr_a_i];
    rdata_b_q <= mem[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// File: src/gsa_free_stack.sv
// LIFO free-slot stack: RAM plus fill count and low-water mark.
// Top and next-to-top are prefetched every cycle. Uses gsa_pkg, gsa_ram.
`default_nettype none

module gsa_free_stack #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  gsa_pkg::stk_cmd_t                cmd_i,
  input  logic [$clog2(MAX_SLOTS+1)-1:0]   fill_count_i,
  input  logic [$clog2(MAX_SLOTS+1)-1:0]   active_i,
  input  logic [$clog2(MAX_SLOTS)-1:0]     push_slot_i,
  output logic [$clog2(MAX_SLOTS+1)-1:0]   count_o,
  output logic [$clog2(MAX_SLOTS)-1:0]     top_o,
  output logic [$clog2(MAX_SLOTS)-1:0]     next_top_o
);

  import gsa_pkg::*;

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);

  logic [CW-1:0] fc_q, fc_d, low_q, low_d;
  logic [CW-1:0] pos_top, pos_next, init_top, init_next;
  logic [CW-1:0] fc_d_m1, fc_d_m2;
  logic          wr_vld_q, wr_vld_d;
  logic [IW-1:0] wr_pos_q, wr_slot_q;
  logic [IW-1:0] ram_top, ram_next, top, nxt;
  logic          ram_we;

  // Positions below the low-water mark were never written since the fill.
  assign pos_top   = fc_q - CW'(1);
  assign pos_next  = fc_q - CW'(2);
  assign init_top  = active_i - fc_q;
  assign init_next = active_i - fc_q + CW'(1);

  always_comb begin
    if (wr_vld_q && (wr_pos_q == pos_top[IW-1:0])) begin
      top = wr_slot_q;
    end else if (pos_top < low_q) begin
      top = init_top[IW-1:0];
    end else begin
      top = ram_top;
    end
    if (wr_vld_q && (wr_pos_q == pos_next[IW-1:0])) begin
      nxt = wr_slot_q;
    end else if (pos_next < low_q) begin
      nxt = init_next[IW-1:0];
    end else begin
      nxt = ram_next;
    end
  end

  always_comb begin
    fc_d       = fc_q;
    low_d      = low_q;
    wr_vld_d   = 1'b0;
    next_top_o = top;
    priority if (cmd_i.refill) begin
      fc_d  = fill_count_i;
      low_d = fill_count_i;
    end else if (cmd_i.push) begin
      fc_d       = fc_q + CW'(1);
      wr_vld_d   = 1'b1;
      next_top_o = push_slot_i;
    end else if (cmd_i.pop) begin
      fc_d       = pos_top;
      next_top_o = nxt;
      if (pos_top < low_q) begin
        low_d = pos_top;
      end
    end else begin
      fc_d = fc_q;
    end
  end

  assign fc_d_m1 = fc_d - CW'(1);
  assign fc_d_m2 = fc_d - CW'(2);
  assign ram_we  = cmd_i.push && !cmd_i.refill;

  gsa_ram #(
    .WIDTH (IW),
    .DEPTH (MAX_SLOTS)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (fc_q[IW-1:0]),
    .wdata_i   (push_slot_i),
    .raddr_a_i (fc_d_m1[IW-1:0]),
    .raddr_b_i (fc_d_m2[IW-1:0]),
    .rdata_a_o (ram_top),
    .rdata_b_o (ram_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q     <= CW'(MAX_SLOTS);
      low_q    <= CW'(MAX_SLOTS);
      wr_vld_q <= 1'b0;
    end else begin
      fc_q     <= fc_d;
      low_q    <= low_d;
      wr_vld_q <= wr_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ram_we) begin
      wr_pos_q  <= fc_q[IW-1:0];
      wr_slot_q <= push_slot_i;
    end
  end

  assign count_o = fc_q;
  assign top_o   = top;

endmodule

`default_nettype wire

// File: src/gsa_gen_table.sv
// Per-slot generation tags: RAM with valid bits and write bypass.
// Two read ports, data for addresses given the cycle before. Uses gsa_pkg, gsa_ram.
`default_nettype none

module gsa_gen_table #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         refill_i,
  input  logic [$clog2(MAX_SLOTS)-1:0] raddr_a_i,
  input  logic [$clog2(MAX_SLOTS)-1:0] raddr_b_i,
  input  logic                         we_i,
  input  logic [$clog2(MAX_SLOTS)-1:0] waddr_i,
  input  logic [gsa_pkg::GEN_W-1:0]    wdata_i,
  output logic [gsa_pkg::GEN_W-1:0]    gen_a_o,
  output logic [gsa_pkg::GEN_W-1:0]    gen_b_o
);

  import gsa_pkg::*;

  localparam int IW = $clog2(MAX_SLOTS);

  logic [MAX_SLOTS-1:0] vld_q;
  logic [IW-1:0]        addr_a_q, addr_b_q, wr_addr_q;
  logic                 wr_vld_q;
  logic [GEN_W-1:0]     wr_data_q, ram_a, ram_b;
  logic                 ram_we;

  assign ram_we = we_i && !refill_i;

  gsa_ram #(
    .WIDTH (GEN_W),
    .DEPTH (MAX_SLOTS)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (waddr_i),
    .wdata_i   (wdata_i),
    .raddr_a_i (raddr_a_i),
    .raddr_b_i (raddr_b_i),
    .rdata_a_o (ram_a),
    .rdata_b_o (ram_b)
  );

  always_comb begin
    if (wr_vld_q && (wr_addr_q == addr_a_q)) begin
      gen_a_o = wr_data_q;
    end else begin
      gen_a_o = vld_q[addr_a_q] ? ram_a : '0;
    end
    if (wr_vld_q && (wr_addr_q == addr_b_q)) begin
      gen_b_o = wr_data_q;
    end else begin
      gen_b_o = vld_q[addr_b_q] ? ram_b : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      wr_vld_q <= 1'b0;
    end else if (refill_i) begin
      vld_q    <= '0;
      wr_vld_q <= 1'b0;
    end else begin
      wr_vld_q <= we_i;
      if (we_i) begin
        vld_q[waddr_i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_a_q <= raddr_a_i;
    addr_b_q <= raddr_b_i;
    if (ram_we) begin
      wr_addr_q <= waddr_i;
      wr_data_q <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: src/generational_slot_allocator.sv
// Generational slot allocator top level: handshake, config, flags, results.
// Uses gsa_pkg, gsa_free_stack, gsa_gen_table.
//
// Usage: requests arrive on the s_axis channel (operation in tuser; index,
// generation and copy flag in tdata), one result beat leaves on m_axis per
// request. Acquire pops a free slot and returns index, generation and byte
// offset; release with the current generation advances the tag and pushes
// the slot back; end pass turns pending slots into failed ones when the copy
// failed; query reports whether a handle is current and its slot readable.
// Throughput is one beat per cycle while m_axis_tready is high: one input
// register and one result register, with the stack top and generation RAM
// reads prefetched and write results forwarded. When m_axis_tready is low
// the result register holds, one more request is taken into the input
// register and then s_axis_tready drops. Reset (and any config write) fills
// the pool with slot 0 on top, zero generations, no failed or pending
// slots; there is no clearing pass, so requests are taken from the first
// cycle after reset. Reset state is MAX_SLOTS slots with readback tracking
// on. Config is to be written when idle, by the user; the block does not
// enforce it.
`default_nettype none

module generational_slot_allocator #(
  parameter int MAX_SLOTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // req_index[5:0], req_generation[37:6], copy_ok[38], zero[39]
  input  logic [gsa_pkg::IN_DW-1:0]     s_axis_tdata,
  // operation[1:0]
  input  logic [gsa_pkg::IN_UW-1:0]     s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // ok[0], slot_index[6:1], slot_generation[38:7], byte_offset[47:39],
  // is_current[48], readable[49], zero[55:50]
  output logic [gsa_pkg::OUT_DW-1:0]    m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [gsa_pkg::CFG_AW-1:0]    cfg_addr_i,
  input  logic [gsa_pkg::CFG_DW-1:0]    cfg_wdata_i
);

  import gsa_pkg::*;

  localparam int IW   = $clog2(MAX_SLOTS);
  localparam int CW   = $clog2(MAX_SLOTS + 1);
  localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

  // input register
  logic             in_vld_q;
  op_e              in_op_q;
  logic [IDX_W-1:0] in_idx_q;
  logic [GEN_W-1:0] in_gen_q;
  logic             in_copy_q;

  // result register
  logic              out_vld_q;
  logic [OUT_DW-1:0] out_data_q, out_data_d;

  logic [CW-1:0] active_q, active_d;
  logic          mode_q, mode_d;
  logic          refill;

  logic [MAX_SLOTS-1:0] failed_q, pending_q;

  logic          accept, advance;
  logic [IW-1:0] idx_slot, top, next_top;
  logic [CW-1:0] fc;
  logic [GEN_W-1:0] gen_a, gen_b;
  logic          in_range, acq_ok, rel_ok;
  logic          res_ok, res_cur, res_rd;
  logic [IDX_W-1:0] res_slot;
  logic [GEN_W-1:0] res_gen;
  logic [OFS_W-1:0] res_ofs;
  logic [IW+2:0]    top_ofs;
  stk_cmd_t      stk_cmd;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // config: any known register write refills the pool
  always_comb begin
    active_d = active_q;
    mode_d   = mode_q;
    refill   = 1'b0;
    if (cfg_we_i) begin
      refill = 1'b1;
      unique case (cfg_addr_i)
        CFG_SLOT_COUNT: begin
          if (32'(cfg_wdata_i) > 32'(MAX_SLOTS)) begin
            active_d = CW'(MAX_SLOTS);
          end else begin
            active_d = CW'(cfg_wdata_i);
          end
        end
        CFG_READBACK_MODE: mode_d = cfg_wdata_i[0];
        default: refill = 1'b0;
      endcase
    end
  end

  assign idx_slot = IW'(in_idx_q);
  assign in_range = CMPW'(in_idx_q) < CMPW'(active_q);
  assign acq_ok   = (in_op_q == OP_ACQUIRE) && (fc != '0);
  assign rel_ok   = (in_op_q == OP_RELEASE) && in_range && (gen_a == in_gen_q) &&
                    (fc < active_q);

  assign stk_cmd.refill = refill;
  assign stk_cmd.push   = advance && rel_ok;
  assign stk_cmd.pop    = advance && acq_ok;

  gsa_free_stack #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_stack (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (stk_cmd),
    .fill_count_i (active_d),
    .active_i     (active_q),
    .push_slot_i  (idx_slot),
    .count_o      (fc),
    .top_o        (top),
    .next_top_o   (next_top)
  );

  gsa_gen_table #(
    .MAX_SLOTS (MAX_SLOTS)
  ) u_gen (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .refill_i  (refill),
    .raddr_a_i (accept ? IW'(s_axis_tdata[IDX_W-1:0]) : idx_slot),
    .raddr_b_i (next_top),
    .we_i      (stk_cmd.push),
    .waddr_i   (idx_slot),
    .wdata_i   (gen_a + GEN_W'(1)),
    .gen_a_o   (gen_a),
    .gen_b_o   (gen_b)
  );

  assign top_ofs = {top, 3'b000};

  always_comb begin
    res_ok   = 1'b0;
    res_slot = '0;
    res_gen  = '0;
    res_ofs  = '0;
    res_cur  = 1'b0;
    res_rd   = 1'b0;
    unique case (in_op_q)
      OP_ACQUIRE: begin
        if (acq_ok) begin
          res_ok   = 1'b1;
          res_slot = IDX_W'(top);
          res_gen  = gen_b;
          res_ofs  = OFS_W'(top_ofs);
        end
      end
      OP_RELEASE: res_ok = rel_ok;
      OP_END_PASS: res_ok = 1'b0;
      OP_QUERY: begin
        res_cur = in_range && (gen_a == in_gen_q);
        res_rd  = in_range && !failed_q[idx_slot];
      end
      default: res_ok = 1'b0;
    endcase
  end

  assign out_data_d = {6'b0, res_rd, res_cur, res_ofs, res_gen, res_slot, res_ok};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      active_q  <= CW'(MAX_SLOTS);
      mode_q    <= 1'b1;
      failed_q  <= '0;
      pending_q <= '0;
    end else begin
      active_q <= active_d;
      mode_q   <= mode_d;
      if (accept) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
      if (refill) begin
        failed_q  <= '0;
        pending_q <= '0;
      end else if (advance) begin
        unique case (in_op_q)
          OP_ACQUIRE: begin
            if (acq_ok) begin
              failed_q[top]  <= 1'b0;
              pending_q[top] <= mode_q;
            end
          end
          OP_END_PASS: begin
            failed_q  <= failed_q | (pending_q & {MAX_SLOTS{!in_copy_q}});
            pending_q <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_op_q   <= op_e'(s_axis_tuser);
      in_idx_q  <= s_axis_tdata[IDX_W-1:0];
      in_gen_q  <= s_axis_tdata[IDX_W+GEN_W-1:IDX_W];
      in_copy_q <= s_axis_tdata[IDX_W+GEN_W];
    end
    if (advance) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// File: src/gsa_checker.sv
// Port-level checker for the generational slot allocator, bound to the top.
// Uses gsa_pkg for port widths.
`default_nettype none

module gsa_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       s_axis_tvalid,
  input logic                       s_axis_tready,
  input logic [gsa_pkg::IN_DW-1:0]  s_axis_tdata,
  input logic [gsa_pkg::IN_UW-1:0]  s_axis_tuser,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [gsa_pkg::OUT_DW-1:0] m_axis_tdata
);

  import gsa_pkg::*;

  logic s_beat;

  assign s_beat = s_axis_tvalid && s_axis_tready;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result beat dropped while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_beat_yields_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_beat && !m_axis_tvalid |=> ##1 m_axis_tvalid)
    else $error("accepted beat gave no result");

  a_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[47:39] == {m_axis_tdata[6:1], 3'b000}))
    else $error("byte offset does not match slot index");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[48] && !m_axis_tdata[49])
    else $error("query flags set on acquire or release result");

endmodule

bind generational_slot_allocator gsa_checker u_gsa_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
